// ----- sv/mbad_pkg.sv -----
// ----------------------------------------------------------------------------
// mbad_pkg
// Shared types and constants of the masked block average downsampler.
// ----------------------------------------------------------------------------
package mbad_pkg;

   localparam int SUM_W = 40;
   localparam int CSUM_W = 16;
   localparam int CNT_W = 9;
   localparam int LINE_W = 3 * SUM_W + 3 * CSUM_W + CNT_W;
   localparam int QUO_W = 40;

   // configuration register indexes
   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BLOCK = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ----- sv/mbad_ram.sv -----
// ----------------------------------------------------------------------------
// mbad_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/mbad_div.sv -----
// ----------------------------------------------------------------------------
// mbad_div
// Radix-2 restoring divider shared over six sums, one quotient bit a cycle.
// Signed sums are divided as magnitudes and the sign applied at the end.
// ----------------------------------------------------------------------------
module mbad_div
   import mbad_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SUM_W-1:0]      dividend,
   input  logic                  is_signed,
   input  logic [CNT_W-1:0]      divisor,
   output logic                  done,
   output logic [QUO_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(QUO_W + 1);

   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W+1:0]  diff;

   // one shift-subtract step
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      trial = {rem_ff[CNT_W-1:0], quo_ff[QUO_W-1]};
      diff = {1'b0, trial} - {2'b00, divisor};
      if (start) begin
         neg_in = is_signed & dividend[SUM_W-1];
         quo_in = (is_signed & dividend[SUM_W-1]) ? (~dividend + 1'b1) : dividend;
         rem_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[CNT_W+1]) begin
            rem_in = diff[CNT_W:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// ----- sv/masked_block_average_downsampler.sv -----
// ----------------------------------------------------------------------------
// masked_block_average_downsampler
// Averages valid points over square tiles using a line store of accumulators.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  req_     | in        | point, colors, valid flag, frame_start in tuser
//  rsp_     | out       | averages, valid flag, row_end in tlast, frame_end in tuser
//  csr_     | in        | register index and value
//
// A pixel that closes no tile is accepted with its memory read, then written back.
// A tile with valid points adds six divisions through the shared divider and
// an output state, held until the result is taken.
// An empty tile adds only the output state. After reset and after each register write
// the input is held off while the tile extents settle.
// The line store needs no clearing pass: the first pixel of a tile overwrites.
// Reset is synchronous; registers return to 640 by 480, block size 2.
module masked_block_average_downsampler
   import mbad_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_BLOCK = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_valid, pos_x, pos_y, pos_z, color_r, color_g, color_b, pad
   input  logic [127:0] req_tdata,
   // frame_start
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // avg_valid, avg_x, avg_y, avg_z, avg_r, avg_g, avg_b, pad
   output logic [127:0] rsp_tdata,
   // row_end
   output logic         rsp_tlast,
   // frame_end
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [10:0]  csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int BW = $clog2(MAX_BLOCK + 1);
   localparam int DW = $clog2(MAX_WIDTH + 1);

   // configuration
   logic [10:0] width_ff, height_ff;
   logic [4:0]  block_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 11'd640;
         height_ff <= 11'd480;
         block_ff <= 5'd2;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_WIDTH:  width_ff <= csr_data;
            REG_HEIGHT: height_ff <= csr_data;
            REG_BLOCK:  block_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // clamped dimensions
   logic [BW-1:0] bs;
   logic [DW-1:0] w, h, out_w, full_w, full_h;
   logic [10:0]   h_c;
   always_comb begin
      bs = (block_ff == 5'd0) ? BW'(1) :
           ({6'd0, block_ff} > 11'(MAX_BLOCK)) ? BW'(MAX_BLOCK) : BW'(block_ff);
      w = (width_ff == 11'd0) ? DW'(1) :
          (32'(width_ff) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(width_ff);
      h_c = (height_ff == 11'd0) ? 11'd1 : (height_ff > 11'd1024) ? 11'd1024 : height_ff;
      h = DW'(h_c);
   end

   // full-tile extents, built one tile per cycle after reset or a register write
   logic [DW-1:0] ow_ff, oh_ff;
   logic [DW-1:0] fw_ff, fh_ff;
   logic [DW-1:0] oh_cnt;
   logic          walk_w, walk_h, ext_busy;
   assign out_w = ow_ff;
   assign full_w = fw_ff;
   assign full_h = fh_ff;
   always_comb begin
      walk_w = ((DW+1)'(fw_ff) + (DW+1)'(bs) <= (DW+1)'(w));
      walk_h = ((DW+1)'(fh_ff) + (DW+1)'(bs) <= (DW+1)'(h));
      ext_busy = walk_w || walk_h;
   end
   always_ff @(posedge clock) begin
      if (reset || csr_valid) begin
         ow_ff <= '0;
         fw_ff <= '0;
         oh_ff <= '0;
         fh_ff <= '0;
      end else begin
         if (walk_w) begin
            ow_ff <= ow_ff + 1'b1;
            fw_ff <= fw_ff + DW'(bs);
         end
         if (walk_h) begin
            oh_ff <= oh_ff + 1'b1;
            fh_ff <= fh_ff + DW'(bs);
         end
      end
   end
   assign oh_cnt = oh_ff;

   // counters
   logic [DW-1:0] pcol_ff, prow_ff;
   logic [BW-1:0] cit_ff, rit_ff;
   logic [AW-1:0] tcol_ff;
   logic [DW-1:0] pcol, prow;
   logic [BW-1:0] cit, rit;
   logic [AW-1:0] tcol;

   // captured pixel
   logic        pv_ff;
   logic [31:0] px_ff, py_ff, pz_ff;
   logic [7:0]  pr_ff, pg_ff, pb_ff;
   logic        fs_ff;

   state_type state_ff, state_in;
   logic [2:0] sel_ff;
   logic       re_ff, fe_ff, av_ff;
   logic [31:0] ox_ff, oy_ff, oz_ff;
   logic [7:0]  or_ff, og_ff, ob_ff;
   logic [LINE_W-1:0] acc_ff;

   // effective counters after frame_start
   always_comb begin
      pcol = fs_ff ? '0 : pcol_ff;
      prow = fs_ff ? '0 : prow_ff;
      cit = fs_ff ? '0 : cit_ff;
      rit = fs_ff ? '0 : rit_ff;
      tcol = fs_ff ? '0 : tcol_ff;
   end

   // line store
   logic [LINE_W-1:0] rd_data, wr_data;
   logic wr_en;
   mbad_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_line (
      .clock(clock), .wr_en(wr_en), .wr_addr(tcol), .wr_data(wr_data),
      .rd_addr(tcol), .rd_data(rd_data)
   );

   // update accumulators
   logic in_tile, first, last;
   logic [SUM_W-1:0]  sx, sy, sz;
   logic [CSUM_W-1:0] sr, sg, sb;
   logic [CNT_W-1:0]  cnt;
   always_comb begin
      in_tile = (pcol < full_w) && (prow < full_h);
      first = (cit == '0) && (rit == '0);
      last = (cit == bs - 1'b1) && (rit == bs - 1'b1);
      {cnt, sb, sg, sr, sz, sy, sx} = first ? '0 : rd_data;
      if (pv_ff) begin
         sx = sx + {{8{px_ff[31]}}, px_ff};
         sy = sy + {{8{py_ff[31]}}, py_ff};
         sz = sz + {{8{pz_ff[31]}}, pz_ff};
         sr = sr + CSUM_W'(pr_ff);
         sg = sg + CSUM_W'(pg_ff);
         sb = sb + CSUM_W'(pb_ff);
         cnt = cnt + 1'b1;
      end
      wr_data = {cnt, sb, sg, sr, sz, sy, sx};
   end

   // divider: the first sum comes straight from the write-back data, the rest
   // from the captured accumulator, each selected for the division about to start
   logic [SUM_W-1:0]  div_num;
   logic              div_sgn, div_done, div_start;
   logic [QUO_W-1:0]  div_q;
   logic [CNT_W-1:0]  acnt;
   logic [2:0]        div_sel;
   logic [LINE_W-1:0] div_src;
   always_comb begin
      div_src = (state_ff == ST_READ) ? wr_data : acc_ff;
      div_sel = (state_ff == ST_READ) ? 3'd0 : sel_ff + 3'd1;
      acnt = acc_ff[LINE_W-1 -: CNT_W];
      div_sgn = (div_sel < 3'd3);
      unique case (div_sel)
         3'd0: div_num = div_src[SUM_W-1:0];
         3'd1: div_num = div_src[2*SUM_W-1 -: SUM_W];
         3'd2: div_num = div_src[3*SUM_W-1 -: SUM_W];
         3'd3: div_num = SUM_W'(div_src[3*SUM_W +: CSUM_W]);
         3'd4: div_num = SUM_W'(div_src[3*SUM_W+CSUM_W +: CSUM_W]);
         default: div_num = SUM_W'(div_src[3*SUM_W+2*CSUM_W +: CSUM_W]);
      endcase
   end
   mbad_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .is_signed(div_sgn), .divisor(acnt), .done(div_done), .quotient(div_q)
   );

   logic tile_done;
   assign tile_done = in_tile && last;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) state_in = ST_READ;
         ST_READ: begin
            if (tile_done) state_in = (wr_data[LINE_W-1 -: CNT_W] != '0) ? ST_DIV : ST_OUT;
            else state_in = ST_IDLE;
         end
         ST_DIV: if (div_done && sel_ff == 3'd5) state_in = ST_OUT;
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer; hold input while the extents settle
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !ext_busy;
      wr_en = (state_ff == ST_READ) && in_tile;
      div_start = ((state_ff == ST_READ) && tile_done &&
                   wr_data[LINE_W-1 -: CNT_W] != '0) ||
                  ((state_ff == ST_DIV) && div_done && sel_ff != 3'd5);
      rsp_tvalid = (state_ff == ST_OUT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pcol_ff <= '0;
         prow_ff <= '0;
         cit_ff <= '0;
         rit_ff <= '0;
         tcol_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_READ) begin
            // advance counters
            if (pcol + 1'b1 >= w) begin
               pcol_ff <= '0;
               cit_ff <= '0;
               tcol_ff <= '0;
               if ((DW+1)'(prow) + 1'b1 >= (DW+1)'(h)) begin
                  prow_ff <= '0;
                  rit_ff <= '0;
               end else begin
                  prow_ff <= prow + 1'b1;
                  rit_ff <= (rit + 1'b1 >= bs) ? '0 : rit + 1'b1;
               end
            end else begin
               pcol_ff <= pcol + 1'b1;
               prow_ff <= prow;
               rit_ff <= rit;
               if (cit + 1'b1 >= bs) begin
                  cit_ff <= '0;
                  tcol_ff <= tcol + 1'b1;
               end else begin
                  cit_ff <= cit + 1'b1;
                  tcol_ff <= tcol;
               end
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pv_ff <= req_tdata[0];
         px_ff <= req_tdata[32:1];
         py_ff <= req_tdata[64:33];
         pz_ff <= req_tdata[96:65];
         pr_ff <= req_tdata[104:97];
         pg_ff <= req_tdata[112:105];
         pb_ff <= req_tdata[120:113];
         fs_ff <= req_tuser;
      end
      if (state_ff == ST_READ) begin
         acc_ff <= wr_data;
         sel_ff <= '0;
         av_ff <= wr_data[LINE_W-1 -: CNT_W] != '0;
         re_ff <= (32'(tcol) + 1 == 32'(out_w));
         fe_ff <= (32'(tcol) + 1 == 32'(out_w)) && (32'(prow) + 1 == 32'(full_h))
                  && (oh_cnt != '0);
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         or_ff <= '0; og_ff <= '0; ob_ff <= '0;
      end
      if (state_ff == ST_DIV && div_done) begin
         unique case (sel_ff)
            3'd0: ox_ff <= div_q[31:0];
            3'd1: oy_ff <= div_q[31:0];
            3'd2: oz_ff <= div_q[31:0];
            3'd3: or_ff <= div_q[7:0];
            3'd4: og_ff <= div_q[7:0];
            default: ob_ff <= div_q[7:0];
         endcase
         sel_ff <= sel_ff + 1'b1;
      end
   end

   assign rsp_tdata = {7'd0, ob_ff, og_ff, or_ff, oz_ff, oy_ff, ox_ff, av_ff};
   assign rsp_tlast = re_ff;
   assign rsp_tuser = fe_ff;

endmodule
